// ----- hdl/remoting_message_deframer_core_defines.svh -----
// Assertion macros shared by the deframer RTL.
`ifndef REMOTING_MESSAGE_DEFRAMER_CORE_DEFINES_SVH
`define REMOTING_MESSAGE_DEFRAMER_CORE_DEFINES_SVH

// Generic form: explicit clock and active-low reset.
`define RMD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Block clock and reset.
`define RMD_ASSERT_CLK(lbl, prop, msg) `RMD_ASSERT(lbl, aclk, aresetn, prop, msg)

`endif

// ----- hdl/rmd_pkg.sv -----
// Types, codes and helpers for the remoting message deframer.
`default_nettype none

package rmd_pkg;

    localparam int BODY_W  = 33;
    localparam int ENTRY_W = 32;
    localparam int POS_W   = 3;

    // Register indexes of the configuration port
    localparam logic CFG_REQUEST_DIRECTION = 1'b0;
    localparam logic CFG_REPORT_BOTH       = 1'b1;

    typedef enum logic [3:0] {
        PH_MARKER  = 4'd0,
        PH_TAG     = 4'd1,
        PH_LENGTH  = 4'd2,
        PH_KEY     = 4'd3,
        PH_KEYREST = 4'd4,
        PH_ELEN    = 4'd5,
        PH_CONTENT = 4'd6,
        PH_PAIR    = 4'd7,
        PH_BODY    = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        CLS_MARKER  = 3'd0,
        CLS_TAG     = 3'd1,
        CLS_LENGTH  = 3'd2,
        CLS_KEY     = 3'd3,
        CLS_ELEN    = 3'd4,
        CLS_CONTENT = 3'd5,
        CLS_BODY    = 3'd6,
        CLS_DISCARD = 3'd7
    } byte_class_t;

    typedef struct packed {
        phase_t               phase;
        logic [POS_W-1:0]     position;
        logic [BODY_W-1:0]    body_remaining;
        logic [ENTRY_W-1:0]   entry_remaining;
        logic                 discarding;
    } dir_state_t;

    // ".NET" 01 00
    function automatic logic [7:0] marker_byte(input logic [POS_W-1:0] p);
        logic [7:0] r;
        case (p)
            3'd0:    r = 8'h2E;
            3'd1:    r = 8'h4E;
            3'd2:    r = 8'h45;
            3'd3:    r = 8'h54;
            3'd4:    r = 8'h01;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Back to the marker phase with cleared counts; discard flag untouched.
    function automatic dir_state_t clear_dir(input dir_state_t s);
        dir_state_t r;
        r                 = s;
        r.phase           = PH_MARKER;
        r.position        = '0;
        r.body_remaining  = '0;
        r.entry_remaining = '0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/remoting_message_deframer_core.sv -----
// Remoting message deframer: top level with per-direction parsers.
//
// Usage: one captured payload byte per s_ transaction, tagged with its
// direction (0 or 1) and a segment-end flag. For every byte one result
// transaction leaves on the m_ channel: the byte class and the error,
// entry-end, message-end, request and reported flags.
// The result of an accepted byte is registered and presented on m_ in
// the next cycle. Throughput is one byte per cycle unless the receiver
// stalls, set by the single output register; the parse state of both
// directions updates in the cycle a byte is accepted.
// When the receiver stalls, the result stays in the output register and
// s_ready drops only while that register is full and m_ready is low.
// Configuration (request direction, report-both) is written on the cfg_
// channel, always ready; the user must write it only while no byte is
// in flight (not enforced). Reset (aresetn low, synchronous) puts both
// directions in the marker phase with cleared counts and no discard,
// empties the output register and clears both configuration registers.
`default_nettype none
`include "remoting_message_deframer_core_defines.svh"

module remoting_message_deframer_core
    import rmd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic        cfg_data,
    // byte input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_direction,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_segment_end,
    // result output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_byte_class,
    output logic             m_parse_error,
    output logic             m_entry_end,
    output logic             m_message_end,
    output logic             m_is_request,
    output logic             m_reported
);

    logic        request_direction_reg;
    logic        report_both_reg;
    dir_state_t  dir0_reg, dir0_next;
    dir_state_t  dir1_reg, dir1_next;

    logic        m_valid_reg;
    byte_class_t byte_class_reg;
    logic        parse_error_reg, entry_end_reg, message_end_reg;
    logic        is_request_reg, reported_reg;

    logic        accept;
    dir_state_t  cur, oth, upd;
    logic        release_other;

    logic [1:0]         pc;
    logic [POS_W-1:0]   pos_inc;
    logic [BODY_W-1:0]  body_len_or, body_len_fin, body_dec;
    logic [ENTRY_W-1:0] elen_or, entry_dec;
    logic               keyrest_bad, keyrest_last, keyrest_want;
    logic               marker_ok;

    byte_class_t cls;
    logic        err, ee, me;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    assign cur = s_direction ? dir1_reg : dir0_reg;
    assign oth = s_direction ? dir0_reg : dir1_reg;

    // shared datapath pieces
    assign pc           = (cur.position > 3'd3) ? 2'd3 : cur.position[1:0];
    assign pos_inc      = cur.position + 3'd1;
    assign body_len_or  = cur.body_remaining | ({25'd0, s_data_byte} << {pc, 3'b000});
    assign body_len_fin = body_len_or + 33'd2;
    assign body_dec     = (cur.body_remaining != '0) ? cur.body_remaining - 33'd1 : '0;
    assign elen_or      = cur.entry_remaining | ({24'd0, s_data_byte} << {pc, 3'b000});
    assign entry_dec    = (cur.entry_remaining != '0) ? cur.entry_remaining - 32'd1 : '0;

    // key tail: 00 01 after key 01, 00 01 01 after key 04/06
    assign keyrest_want = !(cur.position == 3'd1 || cur.position == 3'd5);
    assign keyrest_last = (cur.position == 3'd2) || (cur.position == 3'd7);
    assign keyrest_bad  = (s_data_byte != {7'd0, keyrest_want}) || (cur.position == 3'd0)
                          || (cur.position == 3'd3) || (cur.position == 3'd4);

    // an unused phase code restarts the match at position zero
    assign marker_ok = (cur.phase == PH_MARKER)
                       ? (cur.position < 3'd6 && s_data_byte == marker_byte(cur.position))
                       : (s_data_byte == marker_byte('0));

    // next state of the addressed direction
    always_comb begin
        upd           = cur;
        release_other = 1'b0;
        if (cur.discarding) begin
            if (s_segment_end) begin
                upd.discarding = 1'b0;
            end
        end else begin
            unique case (cur.phase) inside
                PH_TAG: begin
                    if (cur.position >= 3'd3) begin
                        upd.phase          = PH_LENGTH;
                        upd.position       = '0;
                        upd.body_remaining = '0;
                    end else begin
                        upd.position = pos_inc;
                    end
                end
                PH_LENGTH: begin
                    if (pc == 2'd3) begin
                        upd.body_remaining = body_len_fin;
                        upd.phase          = PH_KEY;
                        upd.position       = '0;
                    end else begin
                        upd.body_remaining = body_len_or;
                        upd.position       = {1'b0, pc} + 3'd1;
                    end
                end
                PH_KEY: begin
                    if (s_data_byte == 8'h00) begin
                        upd.body_remaining = body_dec;
                        upd.phase          = PH_PAIR;
                    end else if (s_data_byte == 8'h01) begin
                        upd.phase    = PH_KEYREST;
                        upd.position = 3'd1;
                    end else if (s_data_byte == 8'h04 || s_data_byte == 8'h06) begin
                        upd.phase    = PH_KEYREST;
                        upd.position = 3'd5;
                    end else begin
                        upd            = clear_dir(cur);
                        upd.discarding = !s_segment_end;
                    end
                end
                PH_KEYREST: begin
                    if (keyrest_bad) begin
                        upd            = clear_dir(cur);
                        upd.discarding = !s_segment_end;
                    end else if (keyrest_last) begin
                        upd.phase           = PH_ELEN;
                        upd.position        = '0;
                        upd.entry_remaining = '0;
                    end else begin
                        upd.position = pos_inc;
                    end
                end
                PH_ELEN: begin
                    upd.entry_remaining = elen_or;
                    if (pc == 2'd3) begin
                        upd.position = '0;
                        upd.phase    = (elen_or == '0) ? PH_KEY : PH_CONTENT;
                    end else begin
                        upd.position = {1'b0, pc} + 3'd1;
                    end
                end
                PH_CONTENT: begin
                    upd.entry_remaining = entry_dec;
                    if (entry_dec == '0) begin
                        upd.phase = PH_KEY;
                    end
                end
                PH_PAIR, PH_BODY: begin
                    if (cur.phase == PH_PAIR && s_data_byte != 8'h00) begin
                        upd            = clear_dir(cur);
                        upd.discarding = !s_segment_end;
                    end else if (body_dec == '0) begin
                        upd           = clear_dir(cur);
                        release_other = 1'b1;
                    end else begin
                        upd.body_remaining = body_dec;
                        upd.phase          = PH_BODY;
                    end
                end
                default: begin
                    // marker phase (unused codes land here too)
                    upd           = clear_dir(cur);
                    release_other = 1'b1;
                    if (marker_ok) begin
                        if (cur.phase == PH_MARKER && cur.position == 3'd5) begin
                            upd.phase = PH_TAG;
                        end else if (cur.phase == PH_MARKER) begin
                            upd.position = pos_inc;
                        end else begin
                            upd.position = 3'd1;
                        end
                    end else begin
                        upd.discarding = !s_segment_end;
                    end
                end
            endcase
        end
    end

    // result fields of the byte
    always_comb begin
        cls = CLS_MARKER;
        err = 1'b0;
        ee  = 1'b0;
        me  = 1'b0;
        if (cur.discarding) begin
            cls = CLS_DISCARD;
        end else begin
            unique case (cur.phase) inside
                PH_TAG:    cls = CLS_TAG;
                PH_LENGTH: cls = CLS_LENGTH;
                PH_KEY: begin
                    if (s_data_byte == 8'h00) begin
                        cls = CLS_BODY;
                    end else begin
                        cls = CLS_KEY;
                        err = !(s_data_byte == 8'h01 || s_data_byte == 8'h04
                                || s_data_byte == 8'h06);
                    end
                end
                PH_KEYREST: begin
                    cls = CLS_KEY;
                    err = keyrest_bad;
                end
                PH_ELEN: begin
                    cls = CLS_ELEN;
                    ee  = (pc == 2'd3) && (elen_or == '0);
                end
                PH_CONTENT: begin
                    cls = CLS_CONTENT;
                    ee  = (entry_dec == '0);
                end
                PH_PAIR, PH_BODY: begin
                    if (cur.phase == PH_PAIR && s_data_byte != 8'h00) begin
                        cls = CLS_KEY;
                        err = 1'b1;
                    end else begin
                        cls = CLS_BODY;
                        me  = (body_dec == '0);
                    end
                end
                default: begin
                    cls = CLS_MARKER;
                    err = !marker_ok;
                end
            endcase
        end
    end

    // route updates: addressed direction gets upd, the other may be released
    always_comb begin
        dir0_next = dir0_reg;
        dir1_next = dir1_reg;
        if (accept) begin
            if (s_direction) begin
                dir1_next = upd;
                if (release_other && oth.phase != PH_MARKER) begin
                    dir0_next = clear_dir(dir0_reg);
                end
            end else begin
                dir0_next = upd;
                if (release_other && oth.phase != PH_MARKER) begin
                    dir1_next = clear_dir(dir1_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir0_reg              <= '0;
            dir1_reg              <= '0;
            request_direction_reg <= 1'b0;
            report_both_reg       <= 1'b0;
            m_valid_reg           <= 1'b0;
        end else begin
            dir0_reg <= dir0_next;
            dir1_reg <= dir1_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_REQUEST_DIRECTION: request_direction_reg <= cfg_data;
                    CFG_REPORT_BOTH:       report_both_reg       <= cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            byte_class_reg  <= cls;
            parse_error_reg <= err;
            entry_end_reg   <= ee;
            message_end_reg <= me;
            is_request_reg  <= (s_direction == request_direction_reg);
            reported_reg    <= (s_direction == request_direction_reg) || report_both_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_byte_class  = byte_class_reg;
    assign m_parse_error = parse_error_reg;
    assign m_entry_end   = entry_end_reg;
    assign m_message_end = message_end_reg;
    assign m_is_request  = is_request_reg;
    assign m_reported    = reported_reg;

    `RMD_ASSERT_CLK(a_discard_flags,
        m_valid_reg && byte_class_reg == CLS_DISCARD |->
        !parse_error_reg && !entry_end_reg && !message_end_reg,
        "discarded byte carries a flag")

    `RMD_ASSERT_CLK(a_msg_end_body,
        m_valid_reg && message_end_reg |-> byte_class_reg == CLS_BODY,
        "message end outside body")

    `RMD_ASSERT_CLK(a_err_class,
        m_valid_reg && parse_error_reg |->
        byte_class_reg == CLS_MARKER || byte_class_reg == CLS_KEY,
        "parse error on unexpected class")

    `RMD_ASSERT_CLK(a_entry_end_class,
        m_valid_reg && entry_end_reg |->
        byte_class_reg == CLS_ELEN || byte_class_reg == CLS_CONTENT,
        "entry end on unexpected class")

    `RMD_ASSERT_CLK(a_msg_end_release,
        accept && me |=> dir0_reg.phase == PH_MARKER && dir1_reg.phase == PH_MARKER,
        "direction not released after message end")

endmodule

`default_nettype wire
